@@ hw/rtl/u8sd_pkg.sv @@
// Shared types, constants and lead-byte decoding for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

  // Byte patterns used by the decoder.
  localparam logic [7:0] ContMask    = 8'hC0;
  localparam logic [7:0] ContValue   = 8'h80;
  localparam logic [7:0] InvalidMask = 8'hF8;
  localparam logic [7:0] SepByte     = 8'hFF;
  localparam logic [7:0] SkipMax     = 8'hFF;

  // Decoder state codes; the fourth code acts as idle.
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COLLECT = 2'd1,
    MODE_SKIP    = 2'd2
  } mode_e;

  // Kind of one result.
  typedef enum logic [1:0] {
    KIND_VALID     = 2'd0,
    KIND_ERROR     = 2'd1,
    KIND_SEPARATOR = 2'd2
  } kind_e;

  // One result item.
  typedef struct packed {
    logic [20:0] char_code;
    kind_e       kind;
    logic [7:0]  len;
    logic        last;
  } result_t;

  // Up to two results made by one byte, in output order.
  typedef struct packed {
    logic    first_vld;
    result_t first;
    logic    second_vld;
    result_t second;
  } push_t;

  // Outcome of decoding a byte as a lead byte from idle.
  typedef struct packed {
    logic        res_vld;
    result_t     res;
    mode_e       mode;
    logic [2:0]  exp_len;
    logic [2:0]  held;
    logic [20:0] partial;
    logic [7:0]  skip;
  } lead_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContValue;
  endfunction

  // Decode one byte as the start of a new character.
  function automatic lead_t take_lead(input logic [7:0] b, input logic eob);
    lead_t l;
    l = '0;
    l.mode = MODE_IDLE;
    if (!b[7]) begin
      l.res_vld = 1'b1;
      l.res.char_code = {13'd0, b};
      l.res.kind = KIND_VALID;
      l.res.len = 8'd1;
    end else if ((b & InvalidMask) == InvalidMask) begin
      l.res_vld = 1'b1;
      l.res.kind = (b == SepByte) ? KIND_SEPARATOR : KIND_ERROR;
      l.res.len = 8'd1;
    end else if (eob) begin
      l.res_vld = 1'b1;
      l.res.kind = KIND_ERROR;
      l.res.len = 8'd1;
    end else if (is_cont(b)) begin
      l.mode = MODE_SKIP;
      l.skip = 8'd1;
    end else begin
      l.mode = MODE_COLLECT;
      l.held = 3'd1;
      if (!b[5]) begin
        l.exp_len = 3'd2;
        l.partial = {16'd0, b[4:0]};
      end else if (!b[4]) begin
        l.exp_len = 3'd3;
        l.partial = {17'd0, b[3:0]};
      end else begin
        l.exp_len = 3'd4;
        l.partial = {18'd0, b[2:0]};
      end
    end
    return l;
  endfunction

endpackage

@@ hw/rtl/u8sd_decode.sv @@
// Per-byte decode logic and sequence state registers.
`timescale 1ns / 1ps

module u8sd_decode import u8sd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_buffer_i,
  output push_t      push_o
);

  mode_e       mode_q, mode_d;
  logic [2:0]  exp_q, exp_d;
  logic [2:0]  held_q, held_d;
  logic [20:0] partial_q, partial_d;
  logic [7:0]  skip_q, skip_d;

  lead_t       lead;
  logic [2:0]  held_inc;
  logic [7:0]  skip_inc;
  logic [20:0] partial_shift;
  push_t       push;

  // Next state and the results caused by the current byte.
  always_comb begin
    lead          = take_lead(data_byte_i, end_of_buffer_i);
    held_inc      = held_q + 3'd1;
    skip_inc      = (skip_q == SkipMax) ? skip_q : skip_q + 8'd1;
    partial_shift = {partial_q[14:0], data_byte_i[5:0]};
    mode_d        = mode_q;
    exp_d         = exp_q;
    held_d        = held_q;
    partial_d     = partial_q;
    skip_d        = skip_q;
    push          = '0;

    case (mode_q)
      MODE_COLLECT: begin
        if (is_cont(data_byte_i)) begin
          if (held_inc >= exp_q) begin
            push.second_vld = 1'b1;
            push.second.char_code = partial_shift;
            push.second.kind = KIND_VALID;
            push.second.len = {5'd0, held_inc};
            mode_d = MODE_IDLE;
          end else if (end_of_buffer_i) begin
            push.second_vld = 1'b1;
            push.second.kind = KIND_ERROR;
            push.second.len = {5'd0, held_inc};
            mode_d = MODE_IDLE;
          end else begin
            partial_d = partial_shift;
            held_d = held_inc;
          end
        end else begin
          // Broken sequence: report the prefix, then restart on this byte.
          push.first_vld = 1'b1;
          push.first.kind = KIND_ERROR;
          push.first.len = {5'd0, held_q};
          push.second_vld = lead.res_vld;
          push.second = lead.res;
          mode_d = lead.mode;
          exp_d = lead.exp_len;
          held_d = lead.held;
          partial_d = lead.partial;
          skip_d = lead.skip;
        end
      end
      MODE_SKIP: begin
        if (is_cont(data_byte_i)) begin
          skip_d = skip_inc;
          if (end_of_buffer_i) begin
            push.second_vld = 1'b1;
            push.second.kind = KIND_ERROR;
            push.second.len = skip_inc;
            mode_d = MODE_IDLE;
          end
        end else begin
          // End of a stray run: report it, then restart on this byte.
          push.first_vld = 1'b1;
          push.first.kind = KIND_ERROR;
          push.first.len = skip_q;
          push.second_vld = lead.res_vld;
          push.second = lead.res;
          mode_d = lead.mode;
          exp_d = lead.exp_len;
          held_d = lead.held;
          partial_d = lead.partial;
          skip_d = lead.skip;
        end
      end
      default: begin
        push.second_vld = lead.res_vld;
        push.second = lead.res;
        mode_d = lead.mode;
        exp_d = lead.exp_len;
        held_d = lead.held;
        partial_d = lead.partial;
        skip_d = lead.skip;
      end
    endcase

    // Mark the final result of this byte.
    push.second.last = push.second_vld;
    push.first.last  = push.first_vld && !push.second_vld;

    push_o = push;
    push_o.first_vld  = push.first_vld && accept_i;
    push_o.second_vld = push.second_vld && accept_i;
  end

  // Sequence state, updated on each accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      exp_q     <= 3'd0;
      held_q    <= 3'd0;
      partial_q <= 21'd0;
      skip_q    <= 8'd0;
    end else if (accept_i) begin
      mode_q    <= mode_d;
      exp_q     <= exp_d;
      held_q    <= held_d;
      partial_q <= partial_d;
      skip_q    <= skip_d;
    end
  end

endmodule

@@ hw/rtl/u8sd_queue.sv @@
// Four-entry result queue that takes up to two results per cycle.
`timescale 1ns / 1ps

module u8sd_queue import u8sd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    room_o,
  output logic    valid_o,
  output result_t head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  result_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]     count_q, count_d;
  logic [PtrW-1:0]   second_ptr;
  logic [1:0]        n_push;
  logic              do_pop;

  // Pointer and occupancy bookkeeping.
  always_comb begin
    n_push     = {1'b0, push_i.first_vld} + {1'b0, push_i.second_vld};
    do_pop     = pop_i && (count_q != '0);
    second_ptr = wr_ptr_q + {{(PtrW-1){1'b0}}, push_i.first_vld};
    wr_ptr_d   = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d   = rd_ptr_q + {{(PtrW-1){1'b0}}, do_pop};
    count_d    = count_q + (PtrW+1)'(n_push) - {{PtrW{1'b0}}, do_pop};
  end

  // Room for two results means any byte can be taken.
  assign room_o  = count_q <= (PtrW+1)'(Depth - 2);
  assign valid_o = count_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Result storage, packed in arrival order.
  always_ff @(posedge clk_i) begin
    if (push_i.first_vld) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.second_vld) begin
      mem_q[second_ptr] <= push_i.second;
    end
  end

endmodule

@@ hw/rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake                 Payload
// input    in         in_valid_i / in_stall_o   data_byte_i, end_of_buffer_i
// output   out        out_valid_o / out_stall_i char_code_o, result_kind_o,
//                                               consumed_length_o, last_of_run_o
//
// One byte is taken per cycle while in_stall_o is low; its results enter a four-entry
// queue at the same edge. The first result can leave in the next cycle. A byte that
// ends a broken sequence can give two results, so the sustained rate is one byte per
// cycle while the sink takes one result per cycle, and the queue absorbs the extra
// result. in_stall_o rises when fewer than two queue entries are free. Reset clears
// the decoder to idle and empties the queue.

module utf8_stream_decoder import u8sd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] char_code_o,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  consumed_length_o,
  output logic        last_of_run_o
);

  logic    room;
  logic    accept;
  push_t   push;
  result_t head;

  // A request is accepted when the queue has room for two results.
  assign in_stall_o = !room;
  assign accept     = in_valid_i && room;

  u8sd_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .push_o          (push)
  );

  u8sd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (!out_stall_i),
    .room_o  (room),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign char_code_o       = head.char_code;
  assign result_kind_o     = head.kind;
  assign consumed_length_o = head.len;
  assign last_of_run_o     = head.last;

endmodule

@@ hw/rtl/u8sd_checker.sv @@
// Port-level assertions for the UTF-8 stream decoder, bound to the top level.
`timescale 1ns / 1ps

module u8sd_checker import u8sd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        end_of_buffer_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [20:0] char_code_o,
  input logic [1:0]  result_kind_o,
  input logic [7:0]  consumed_length_o,
  input logic        last_of_run_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(char_code_o) && $stable(result_kind_o)
      && $stable(consumed_length_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // A byte that ends the buffer always leaves a result waiting.
  a_eob_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && end_of_buffer_i |=> out_valid_o)
    else $error("end of buffer produced no result");

  // Error and separator results carry no code point; separators take one byte.
  a_kind_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_VALID |->
      char_code_o == 21'd0
      && (result_kind_o == KIND_ERROR
          || (result_kind_o == KIND_SEPARATOR && consumed_length_o == 8'd1)))
    else $error("malformed error or separator result");

endmodule

bind utf8_stream_decoder u8sd_checker u_u8sd_checker (.*);
